[rtl/hmmws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmmws_pkg
// Types, constants and cost arithmetic shared by the word sequence decoder.
// ----------------------------------------------------------------------------
package hmmws_pkg;

  localparam int MAX_WORDS = 512;
  localparam int WORD_BITS = $clog2(MAX_WORDS);
  localparam int NW_BITS   = WORD_BITS + 1;
  localparam int MAX_LEN   = 64;
  localparam int POS_BITS  = $clog2(MAX_LEN);
  localparam int CNT_BITS  = POS_BITS + 1;
  localparam int COST_BITS = 16;

  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TRANS = 2'd1,
    CMD_EMIT  = 2'd2,
    CMD_OBS   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WORD,
    ST_SCAN,
    ST_EMIT,
    ST_WRITE,
    ST_DONE,
    ST_FIN,
    ST_FEND,
    ST_TBI,
    ST_TBR,
    ST_TBW,
    ST_ORD,
    ST_OLD,
    ST_OWAIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic                 accept;
    logic                 best_clr;
    logic                 scan_rd;
    logic                 emit_rd;
    logic                 word_wr;
    logic                 word_off;
    logic                 fin_rd;
    logic                 tb_init;
    logic                 tb_rd;
    logic                 tb_wr;
    logic                 out_rd;
    logic                 out_ld;
    logic                 out_last;
    logic [WORD_BITS-1:0] w;
    logic [WORD_BITS-1:0] u;
    logic [CNT_BITS-1:0]  pos;
    logic [POS_BITS-1:0]  tpos;
    logic [NW_BITS-1:0]   nw;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_taken;
  } dp_stat_t;

  // saturating cost sum; all-ones is absorbing
  function automatic logic [COST_BITS-1:0] cost_add(input logic [COST_BITS-1:0] a,
                                                    input logic [COST_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == COST_INF || b == COST_INF) begin
      return COST_INF;
    end else if (s >= {1'b0, COST_INF}) begin
      return COST_INF - COST_BITS'(1);
    end else begin
      return s[COST_BITS-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/hmmws_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmmws_ctrl
// Sequencer: step, final search, traceback and result delivery.
// ----------------------------------------------------------------------------
module hmmws_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 cmd_i,
  input  wire logic                       last_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [9:0]                 cfg_wdata_i,
  input  wire hmmws_pkg::dp_stat_t        stat_i,
  output hmmws_pkg::dp_cmd_t              cmd_o
);
  import hmmws_pkg::*;

  state_e               state_q, state_d;
  logic [WORD_BITS-1:0] w_q, w_d, u_q, u_d;
  logic [CNT_BITS-1:0]  pos_q, pos_d;
  logic [POS_BITS-1:0]  tpos_q, tpos_d;
  logic                 last_q, last_d;
  logic [9:0]           num_words_q;
  logic [NW_BITS-1:0]   nw;
  logic                 accept, w_on, w_end;
  logic [CNT_BITS-1:0]  pos_m1;

  always_comb begin
    if (num_words_q == '0) begin
      nw = NW_BITS'(1);
    end else if ({1'b0, num_words_q} > 11'(MAX_WORDS)) begin
      nw = NW_BITS'(MAX_WORDS);
    end else begin
      nw = NW_BITS'(num_words_q);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign w_on       = {1'b0, w_q} < nw;
  assign w_end      = (w_q == WORD_BITS'(MAX_WORDS - 1));
  assign pos_m1     = pos_q - CNT_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      w_q         <= '0;
      u_q         <= '0;
      pos_q       <= '0;
      tpos_q      <= '0;
      last_q      <= 1'b0;
      num_words_q <= 10'(MAX_WORDS);
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      u_q     <= u_d;
      pos_q   <= pos_d;
      tpos_q  <= tpos_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        num_words_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    u_d     = u_q;
    pos_d   = pos_q;
    tpos_d  = tpos_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.accept   = accept;
    cmd_o.w        = w_q;
    cmd_o.u        = u_q;
    cmd_o.pos      = pos_q;
    cmd_o.tpos     = tpos_q;
    cmd_o.nw       = nw;
    cmd_o.out_last = ({1'b0, tpos_q} == pos_m1);
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i == CMD_OBS) begin
          cmd_o.best_clr = 1'b1;
          last_d = last_i;
          w_d    = '0;
          if (pos_q < CNT_BITS'(MAX_LEN)) begin
            state_d = ST_WORD;
          end else if (last_i) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_WORD: begin
        u_d = '0;
        if (!w_on) begin
          cmd_o.word_wr  = 1'b1;
          cmd_o.word_off = 1'b1;
          if (w_end) begin
            state_d = ST_DONE;
          end else begin
            w_d = w_q + WORD_BITS'(1);
          end
        end else if (pos_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if ({1'b0, u_q} == nw - NW_BITS'(1)) begin
          state_d = ST_EMIT;
        end else begin
          u_d = u_q + WORD_BITS'(1);
        end
      end
      ST_EMIT: begin
        cmd_o.emit_rd = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.word_wr  = 1'b1;
        cmd_o.best_clr = 1'b1;
        if (w_end) begin
          state_d = ST_DONE;
        end else begin
          w_d     = w_q + WORD_BITS'(1);
          state_d = ST_WORD;
        end
      end
      ST_DONE: begin
        cmd_o.best_clr = 1'b1;
        pos_d = pos_q + CNT_BITS'(1);
        w_d   = '0;
        state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        cmd_o.fin_rd = 1'b1;
        if ({1'b0, w_q} == nw - NW_BITS'(1)) begin
          state_d = ST_FEND;
        end else begin
          w_d = w_q + WORD_BITS'(1);
        end
      end
      ST_FEND: begin
        state_d = ST_TBI;
      end
      ST_TBI: begin
        cmd_o.tb_init = 1'b1;
        cmd_o.tpos    = pos_m1[POS_BITS-1:0];
        tpos_d = pos_m1[POS_BITS-1:0];
        state_d = (pos_m1 == '0) ? ST_ORD : ST_TBR;
      end
      ST_TBR: begin
        cmd_o.tb_rd = 1'b1;
        state_d = ST_TBW;
      end
      ST_TBW: begin
        cmd_o.tb_wr = 1'b1;
        tpos_d = tpos_q - POS_BITS'(1);
        state_d = (tpos_q == POS_BITS'(1)) ? ST_ORD : ST_TBR;
      end
      ST_ORD: begin
        cmd_o.out_rd = 1'b1;
        state_d = ST_OLD;
      end
      ST_OLD: begin
        cmd_o.out_ld = 1'b1;
        state_d = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (stat_i.out_taken) begin
          if ({1'b0, tpos_q} == pos_m1) begin
            pos_d   = '0;
            state_d = ST_IDLE;
          end else begin
            tpos_d  = tpos_q + POS_BITS'(1);
            state_d = ST_ORD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/hmmws_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmmws_dp
// Cost tables, path costs, back pointers, min-search unit and result register.
// ----------------------------------------------------------------------------
module hmmws_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire hmmws_pkg::dp_cmd_t                cmd_i,
  output hmmws_pkg::dp_stat_t                    stat_o,
  input  wire logic [1:0]                        in_cmd_i,
  input  wire logic [hmmws_pkg::WORD_BITS-1:0]   row_word_i,
  input  wire logic [hmmws_pkg::WORD_BITS-1:0]   col_word_i,
  input  wire logic [hmmws_pkg::COST_BITS-1:0]   cost_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [hmmws_pkg::WORD_BITS-1:0]        word_index_o,
  output logic [hmmws_pkg::POS_BITS-1:0]         position_o,
  output logic                                   found_o,
  output logic                                   last_res_o
);
  import hmmws_pkg::*;

  localparam int TAB_DEPTH = MAX_WORDS * MAX_WORDS;
  localparam int BP_DEPTH  = MAX_LEN * MAX_WORDS;

  logic [COST_BITS-1:0] start_mem [MAX_WORDS];
  logic [COST_BITS-1:0] trans_mem [TAB_DEPTH];
  logic [COST_BITS-1:0] emit_mem  [TAB_DEPTH];
  logic [COST_BITS-1:0] path_mem  [2*MAX_WORDS];
  logic [WORD_BITS-1:0] bp_mem    [BP_DEPTH];
  logic [WORD_BITS-1:0] seq_mem   [MAX_LEN];

  logic [WORD_BITS-1:0] obs_q;
  logic [COST_BITS-1:0] path_rd_q, trans_rd_q, start_rd_q, emit_rd_q;
  logic [WORD_BITS-1:0] bp_rd_q, seq_rd_q, tag_q, trace_q, arg_q;
  logic                 cmp_v_q, cmp_raw_q, obs_ok_q, found_q;
  logic [COST_BITS-1:0] best_q, cand, base, em, new_cost;
  logic                 rd_half, wr_half, out_take;

  assign rd_half = ~cmd_i.pos[0];
  assign wr_half = cmd_i.pos[0];

  // table loads and observation latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      case (cmd_e'(in_cmd_i))
        CMD_START: start_mem[col_word_i] <= cost_i;
        CMD_TRANS: trans_mem[{row_word_i, col_word_i}] <= cost_i;
        CMD_EMIT:  emit_mem[{row_word_i, col_word_i}] <= cost_i;
        CMD_OBS:   obs_q <= col_word_i;
        default:   obs_q <= obs_q;
      endcase
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      path_rd_q  <= path_mem[{rd_half, cmd_i.u}];
      trans_rd_q <= trans_mem[{cmd_i.u, cmd_i.w}];
    end else if (cmd_i.fin_rd) begin
      path_rd_q  <= path_mem[{rd_half, cmd_i.w}];
    end
    if (cmd_i.emit_rd) begin
      start_rd_q <= start_mem[cmd_i.w];
      emit_rd_q  <= emit_mem[{cmd_i.w, obs_q}];
      obs_ok_q   <= {1'b0, obs_q} < cmd_i.nw;
    end
    if (cmd_i.tb_rd) begin
      bp_rd_q <= bp_mem[{cmd_i.tpos, trace_q}];
    end
    if (cmd_i.out_rd) begin
      seq_rd_q <= seq_mem[cmd_i.tpos];
    end
  end

  // min-search pipeline tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_v_q <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.scan_rd || cmd_i.fin_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_raw_q <= cmd_i.fin_rd;
    tag_q     <= cmd_i.fin_rd ? cmd_i.w : cmd_i.u;
  end

  assign cand = cmp_raw_q ? path_rd_q : cost_add(path_rd_q, trans_rd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.best_clr) begin
      best_q <= COST_INF;
      arg_q  <= '0;
    end else if (cmp_v_q && cand < best_q) begin
      best_q <= cand;
      arg_q  <= tag_q;
    end
  end

  // word update
  assign base     = (cmd_i.pos == '0) ? start_rd_q : best_q;
  assign em       = obs_ok_q ? emit_rd_q : COST_INF;
  assign new_cost = cmd_i.word_off ? COST_INF : cost_add(base, em);

  always_ff @(posedge clk_i) begin
    if (cmd_i.word_wr) begin
      path_mem[{wr_half, cmd_i.w}] <= new_cost;
      bp_mem[{cmd_i.pos[POS_BITS-1:0], cmd_i.w}] <= cmd_i.word_off ? '0 : arg_q;
    end
  end

  // traceback
  always_ff @(posedge clk_i) begin
    if (cmd_i.tb_init) begin
      seq_mem[cmd_i.tpos] <= arg_q;
      trace_q <= arg_q;
      found_q <= best_q != COST_INF;
    end else if (cmd_i.tb_wr) begin
      seq_mem[cmd_i.tpos - POS_BITS'(1)] <= bp_rd_q;
      trace_q <= bp_rd_q;
    end
  end

  // result register
  assign out_take         = out_valid_o && !out_stall_i;
  assign stat_o.out_taken = out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_o <= 1'b1;
    end else if (out_take) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      word_index_o <= found_q ? seq_rd_q : '0;
      position_o   <= cmd_i.tpos;
      found_o      <= found_q;
      last_res_o   <= cmd_i.out_last;
    end
  end

endmodule
`default_nettype wire

[rtl/hmm_most_likely_word_sequence.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_most_likely_word_sequence
// Viterbi decoder over a hidden Markov word model with negative-log costs.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | in_valid_i / in_stall_o    | cmd_i row_word_i col_word_i cost_i last_i
//  output   | out_valid_o / out_stall_i  | word_index_o position_o found_o last_res_o
//  config   | cfg_we_i                   | cfg_wdata_i (num_words)
//
// A load word is taken without a stall. An observation word holds the input
// stalled while all MAX_WORDS word slots are updated; each of the N active words
// scans N predecessors, one path/transition read per cycle, except at position 0.
// After the last word: final search over the N path costs, traceback position by
// position, then one result at a time, each held until taken past any output stall.
// Reset clears the controller and num_words (512); the tables are not cleared.
// ----------------------------------------------------------------------------
module hmm_most_likely_word_sequence (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        cmd_i,
  input  wire logic [hmmws_pkg::WORD_BITS-1:0]   row_word_i,
  input  wire logic [hmmws_pkg::WORD_BITS-1:0]   col_word_i,
  input  wire logic [hmmws_pkg::COST_BITS-1:0]   cost_i,
  input  wire logic                              last_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [9:0]                        cfg_wdata_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [hmmws_pkg::WORD_BITS-1:0]        word_index_o,
  output logic [hmmws_pkg::POS_BITS-1:0]         position_o,
  output logic                                   found_o,
  output logic                                   last_res_o
);
  import hmmws_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: walks words, predecessors, traceback and delivery
  hmmws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .last_i      (last_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // tables, min-search and result register
  hmmws_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .in_cmd_i     (cmd_i),
    .row_word_i   (row_word_i),
    .col_word_i   (col_word_i),
    .cost_i       (cost_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .position_o   (position_o),
    .found_o      (found_o),
    .last_res_o   (last_res_o)
  );

  // no new word is taken while a result is pending
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during delivery");

  // an unfound sentence reports word zero
  a_unfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (word_index_o == '0)) else $error("bad unfound word");

  // the final result hands the input back
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_res_o) |=> (!out_valid_o && !in_stall_o))
    else $error("sentence end did not release input");

endmodule
`default_nettype wire
